// File: design/mhe_pkg.sv
// Shared constants and codes of the min-heap extract block.
package mhe_pkg;

    // Number of keys the heap can hold.
    localparam int CAPACITY = 16;

    localparam int KEY_W   = 32;
    localparam int STAT_W  = 2;
    localparam int ENTRY_W = 5;

    // Store address width, fill count width and child index width.
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CHILD_W = IDX_W + 2;

    localparam logic OP_APPEND  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

// File: design/mhe_req_if.sv
// Request channel of the min-heap extract block.
interface mhe_req_if;
    logic                             valid;
    logic                             ready;
    logic                             opcode;
    logic signed [mhe_pkg::KEY_W-1:0] key_value;

    modport source (output valid, output opcode, output key_value, input ready);
    modport sink   (input valid, input opcode, input key_value, output ready);
endinterface

// File: design/mhe_rsp_if.sv
// Response channel of the min-heap extract block.
interface mhe_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [mhe_pkg::KEY_W-1:0]   min_key;
    logic        [mhe_pkg::STAT_W-1:0]  status;
    logic        [mhe_pkg::ENTRY_W-1:0] entry_count;

    modport source (output valid, output min_key, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input min_key, input status, input entry_count,
                    output ready);
endinterface

// File: design/min_heap_extract.sv
// Binary min-heap of signed keys with append and extract-minimum transactions.
//
// The block keeps up to mhe_pkg::CAPACITY signed 32-bit keys in a single-port-read,
// single-port-write memory plus a fill count. An append transaction writes its key at
// the end of the heap (no sift-up: keys must arrive in heap order) and produces its
// response in a register on acceptance. An extract transaction returns the root: the
// sequencer reads the root, then reads the last entry, then checks whether the hole
// has a child. Each level the key moves down takes a read of the left child, a read
// of the right child with a compare, and the move of one entry. Where the key stops
// above a leaf, a final read of the children and compare comes before the key is
// written. With 16 entries at most 15 keys remain once the root is gone, so the key
// moves down at most 3 levels. The one memory read port and the single shared signed
// comparator make the sequencer take these reads and compares one at a time. Extract
// from an empty heap and append to a full heap answer with an error status and leave
// the heap as it was. Each request yields exactly one response transaction; a new
// request is taken once the previous response is gone or is being taken in the same
// cycle.
module min_heap_extract (
    input  logic          clk,
    input  logic          rst_n,
    mhe_req_if.sink       req,
    mhe_rsp_if.source     rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT,
        S_LAST,
        S_LEFT,
        S_RIGHT,
        S_PICK
    } state_t;

    // Heap storage; its contents are undefined until written.
    logic signed [mhe_pkg::KEY_W-1:0] heap_mem [mhe_pkg::CAPACITY];

    state_t                             state_reg,       state_next;
    logic        [mhe_pkg::CNT_W-1:0]   count_reg,       count_next;
    logic        [mhe_pkg::IDX_W-1:0]   pos_reg,         pos_next;
    logic signed [mhe_pkg::KEY_W-1:0]   key_reg,         key_next;
    logic signed [mhe_pkg::KEY_W-1:0]   best_val_reg,    best_val_next;
    logic        [mhe_pkg::IDX_W-1:0]   best_idx_reg,    best_idx_next;
    logic                               best_ok_reg,     best_ok_next;
    logic                               out_valid_reg,   out_valid_next;
    logic signed [mhe_pkg::KEY_W-1:0]   min_key_reg,     min_key_next;
    logic        [mhe_pkg::STAT_W-1:0]  status_reg,      status_next;
    logic        [mhe_pkg::ENTRY_W-1:0] entry_count_reg, entry_count_next;

    // Memory ports.
    logic        [mhe_pkg::IDX_W-1:0] rd_addr;
    logic signed [mhe_pkg::KEY_W-1:0] rd_data_reg;
    logic                             wr_en;
    logic        [mhe_pkg::IDX_W-1:0] wr_addr;
    logic signed [mhe_pkg::KEY_W-1:0] wr_data;

    // The shared comparator.
    logic signed [mhe_pkg::KEY_W-1:0] cmp_a;
    logic signed [mhe_pkg::KEY_W-1:0] cmp_b;
    logic                             cmp_lt;

    // Child positions of the current hole, wide enough never to wrap.
    logic [mhe_pkg::CHILD_W-1:0] left_idx;
    logic [mhe_pkg::CHILD_W-1:0] right_idx;
    logic [mhe_pkg::CHILD_W-1:0] count_ext;
    logic                        left_in;
    logic                        right_in;

    logic req_take;
    logic out_free;

    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + mhe_pkg::CHILD_W'(1);
    assign count_ext = mhe_pkg::CHILD_W'(count_reg);
    assign left_in   = (left_idx < count_ext);
    assign right_in  = (right_idx < count_ext);

    assign cmp_lt = (cmp_a < cmp_b);

    // A new request waits until the previous response has left or is leaving now.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign req_take  = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.min_key     = min_key_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = entry_count_reg;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        key_next         = key_reg;
        best_val_next    = best_val_reg;
        best_idx_next    = best_idx_reg;
        best_ok_next     = best_ok_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        min_key_next     = min_key_reg;
        status_next      = status_reg;
        entry_count_next = entry_count_reg;

        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = key_reg;
        cmp_a   = rd_data_reg;
        cmp_b   = key_reg;

        case (state_reg)
            S_IDLE:
            begin
                // The root is always fetched so that it is ready if this is an extract.
                rd_addr = '0;
                if (req_take)
                begin
                    if (req.opcode == mhe_pkg::OP_APPEND)
                    begin
                        min_key_next   = '0;
                        out_valid_next = 1'b1;
                        if (count_reg >= mhe_pkg::CNT_W'(mhe_pkg::CAPACITY))
                        begin
                            status_next      = mhe_pkg::ST_FULL;
                            entry_count_next = mhe_pkg::ENTRY_W'(count_reg);
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            wr_addr          = count_reg[mhe_pkg::IDX_W-1:0];
                            wr_data          = req.key_value;
                            count_next       = count_reg + mhe_pkg::CNT_W'(1);
                            status_next      = mhe_pkg::ST_OK;
                            entry_count_next = mhe_pkg::ENTRY_W'(count_next);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        min_key_next     = '0;
                        status_next      = mhe_pkg::ST_EMPTY;
                        entry_count_next = mhe_pkg::ENTRY_W'(count_reg);
                        out_valid_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = S_ROOT;
                    end
                end
            end

            S_ROOT:
            begin
                // Root arrives; fetch the last entry, which becomes the sifted key.
                min_key_next = rd_data_reg;
                rd_addr      = mhe_pkg::IDX_W'(count_reg - mhe_pkg::CNT_W'(1));
                state_next   = S_LAST;
            end

            S_LAST:
            begin
                key_next   = rd_data_reg;
                count_next = count_reg - mhe_pkg::CNT_W'(1);
                pos_next   = '0;
                state_next = S_LEFT;
            end

            S_LEFT:
            begin
                if (left_in)
                begin
                    rd_addr    = left_idx[mhe_pkg::IDX_W-1:0];
                    state_next = S_RIGHT;
                end
                else
                begin
                    // The hole is a leaf: the key settles here.
                    wr_en            = 1'b1;
                    wr_addr          = pos_reg;
                    wr_data          = key_reg;
                    status_next      = mhe_pkg::ST_OK;
                    entry_count_next = mhe_pkg::ENTRY_W'(count_reg);
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            S_RIGHT:
            begin
                // Left child against the sifted key.
                cmp_a   = rd_data_reg;
                cmp_b   = key_reg;
                rd_addr = right_idx[mhe_pkg::IDX_W-1:0];
                if (cmp_lt)
                begin
                    best_ok_next  = 1'b1;
                    best_idx_next = left_idx[mhe_pkg::IDX_W-1:0];
                    best_val_next = rd_data_reg;
                end
                else
                begin
                    best_ok_next  = 1'b0;
                    best_val_next = key_reg;
                end
                state_next = S_PICK;
            end

            S_PICK:
            begin
                // Right child against the smaller of key and left child; a tie keeps the earlier choice.
                cmp_a = rd_data_reg;
                cmp_b = best_val_reg;
                if (right_in && cmp_lt)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data    = rd_data_reg;
                    pos_next   = right_idx[mhe_pkg::IDX_W-1:0];
                    state_next = S_LEFT;
                end
                else if (best_ok_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data    = best_val_reg;
                    pos_next   = best_idx_reg;
                    state_next = S_LEFT;
                end
                else
                begin
                    wr_en            = 1'b1;
                    wr_addr          = pos_reg;
                    wr_data          = key_reg;
                    status_next      = mhe_pkg::ST_OK;
                    entry_count_next = mhe_pkg::ENTRY_W'(count_reg);
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            pos_reg         <= '0;
            key_reg         <= '0;
            best_val_reg    <= '0;
            best_idx_reg    <= '0;
            best_ok_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            min_key_reg     <= '0;
            status_reg      <= mhe_pkg::ST_OK;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            pos_reg         <= pos_next;
            key_reg         <= key_next;
            best_val_reg    <= best_val_next;
            best_idx_reg    <= best_idx_next;
            best_ok_reg     <= best_ok_next;
            out_valid_reg   <= out_valid_next;
            min_key_reg     <= min_key_next;
            status_reg      <= status_next;
            entry_count_reg <= entry_count_next;
        end
    end

    // Heap memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= heap_mem[rd_addr];
    end

`ifndef SYNTHESIS
    // The fill count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mhe_pkg::CNT_W'(mhe_pkg::CAPACITY))
        else $error("heap count exceeds capacity");

    // An extract from an empty heap is answered from a register with the empty status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.opcode == mhe_pkg::OP_EXTRACT) && (count_reg == '0))
        |=> (rsp.valid && (rsp.status == mhe_pkg::ST_EMPTY)))
        else $error("empty extract not flagged");

    // While choosing a child, the hole lies inside the heap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PICK) |-> (mhe_pkg::CHILD_W'(pos_reg) < count_ext))
        else $error("sift position outside heap");

    // A response's key and status are never overwritten while it waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.min_key)
                                       && $stable(rsp.status)))
        else $error("pending response changed");
`endif

endmodule
